[rtl/hpsgh_pkg.sv]
// shared types and constants for the hand point smoother
package hpsgh_pkg;

    localparam int COORD_W  = 13;
    localparam int WEIGHT_W = 9;
    localparam int MARGIN_W = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [WEIGHT_W-1:0] GRAB_ONE  = 9'd256;
    localparam logic [9:0]          GRAB_HALF = 10'd128;

    localparam logic [WEIGHT_W-1:0]   WEIGHT_RESET = 9'd128;
    localparam logic [MARGIN_W-1:0]   MARGIN_RESET = 8'd26;
    localparam logic [COORD_W-1:0]    NEAR_RESET   = 13'd700;
    localparam logic [COORD_W-1:0]    FAR_RESET    = 13'd1700;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMOOTHING_WEIGHT = 2'd0,
        CFG_CHANGE_MARGIN    = 2'd1,
        CFG_NEAR_WARNING     = 2'd2,
        CFG_FAR_WARNING      = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WIN,
        ST_GRAB,
        ST_HYST,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        AX_X,
        AX_Y,
        AX_Z
    } axis_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic        [COORD_W-1:0] z;
    } point_t;

    typedef struct packed {
        logic  in_ready;
        logic  win_en;
        logic  grab_en;
        logic  hyst_en;
        logic  div_start;
        axis_t div_axis;
        logic  out_load;
    } ctl_t;

endpackage

[rtl/hpsgh_if.sv]
// item channels: hand point in, smoothed result out
interface hpsgh_point_if
    import hpsgh_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] hand_x;
    logic signed [COORD_W-1:0] hand_y;
    logic        [COORD_W-1:0] hand_z;
    logic                      grab_seen;

    modport source (output valid, hand_x, hand_y, hand_z, grab_seen, input ready);
    modport sink   (input valid, hand_x, hand_y, hand_z, grab_seen, output ready);
endinterface

interface hpsgh_result_if
    import hpsgh_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] smooth_x;
    logic signed [COORD_W-1:0] smooth_y;
    logic        [COORD_W-1:0] smooth_z;
    logic                      grabbing;
    logic                      grab_started;
    logic                      grab_released;
    logic                      too_close;
    logic                      too_far;

    modport source (output valid, smooth_x, smooth_y, smooth_z, grabbing, grab_started,
                    grab_released, too_close, too_far, input ready);
    modport sink   (input valid, smooth_x, smooth_y, smooth_z, grabbing, grab_started,
                    grab_released, too_close, too_far, output ready);
endinterface

[rtl/hpsgh_div.sv]
// iterative restoring divider, one quotient bit per cycle
module hpsgh_div
    import hpsgh_pkg::*;
#(
    parameter int DVD_W = 17,
    parameter int DVS_W = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [DVS_W-1:0]  rem_reg, rem_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic [DVS_W-1:0]  dvs_reg, dvs_next;
    logic [DVS_W:0]    trial;
    logic              fits;

    always_comb
    begin
        trial = {rem_reg, quo_reg[DVD_W-1]};
        fits  = (trial >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = STEP_W'(DVD_W);
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            // shift in next dividend bit, subtract when divisor fits
            rem_next  = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : DVS_W'(trial);
            quo_next  = {quo_reg[DVD_W-2:0], fits};
            step_next = step_reg - 1'b1;
            if (step_reg == STEP_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    property p_done_after_busy;
        @(posedge clk) disable iff (!rst_n) done_reg |-> $past(busy_reg);
    endproperty
    a_done_after_busy: assert property (p_done_after_busy)
        else $error("divider finished without running");

    property p_rem_below_divisor;
        @(posedge clk) disable iff (!rst_n)
            (busy_reg && !$past(start)) |-> (rem_reg < dvs_reg);
    endproperty
    a_rem_below_divisor: assert property (p_rem_below_divisor)
        else $error("divider remainder reached divisor");

    property p_no_restart;
        @(posedge clk) disable iff (!rst_n) busy_reg |-> !start;
    endproperty
    a_no_restart: assert property (p_no_restart)
        else $error("divider started while busy");

endmodule

[rtl/hand_point_smoother_grab_hysteresis.sv]
// hand point smoother: windowed mean of x/y/z, grab average with hysteresis, depth warnings
//
//  channel  | dir | handshake      | content
//  ---------+-----+----------------+-----------------------------------------------
//  point    | in  | valid / ready  | hand_x, hand_y, hand_z, grab_seen
//  result   | out | valid / ready  | smooth_x/y/z, grabbing, start/release, warnings
//  cfg      | in  | cfg_wr_en only | cfg_index selects register, cfg_data written
//
// after accept the item passes ST_WIN, ST_GRAB and ST_HYST, which starts the x division;
// ST_DIV chains y and z, ST_OUT loads the free result register, and ST_IDLE takes the next item
// the three axis divisions (SUM_W = 14 + clog2(WINDOW_POINTS)) share one bit-serial divider
// point.ready is high only while the sequencer idles; a finished result waits in the
// output register, so the next item is taken while result.ready is low
// reset is asynchronous and active low; no clearing pass, window entries are
// used only after they have been written
module hand_point_smoother_grab_hysteresis
    import hpsgh_pkg::*;
#(
    parameter int WINDOW_POINTS = 5
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    hpsgh_point_if.sink           point,
    hpsgh_result_if.source        result
);

    // counter and accumulator widths follow from the window depth
    localparam int CNT_W  = $clog2(WINDOW_POINTS + 1);
    localparam int SLOT_W = (WINDOW_POINTS > 1) ? $clog2(WINDOW_POINTS) : 1;
    localparam int SUM_W  = COORD_W + 1 + $clog2(WINDOW_POINTS);

    // configuration registers
    logic [WEIGHT_W-1:0] weight_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [COORD_W-1:0]  near_reg;
    logic [COORD_W-1:0]  far_reg;

    // sequencer
    state_t state_reg, state_next;
    axis_t  axis_reg, axis_next;
    ctl_t   ctl;

    // captured item
    point_t pt_reg;
    logic   seen_reg;

    // window and running sums
    point_t                   win_mem [WINDOW_POINTS];
    point_t                   old_pt_reg;
    logic [CNT_W-1:0]         held_reg, held_next;
    logic [SLOT_W-1:0]        slot_reg, slot_next;
    logic signed [SUM_W-1:0]  sum_x_reg, sum_y_reg, sum_z_reg;
    logic signed [SUM_W-1:0]  sum_x_next, sum_y_next, sum_z_next;
    logic                     full;

    // grab average and hysteresis
    logic [WEIGHT_W-1:0]      grab_reg, grab_next;
    logic                     active_reg, active_next;
    logic                     started_reg, released_reg;
    logic                     started_next, released_next;
    logic [WEIGHT_W-1:0]      w_eff;
    logic [2*WEIGHT_W-1:0]    grab_prod;
    logic [2*WEIGHT_W-1:0]    grab_sum;
    logic [9:0]               r_ext, m_ext;

    // division
    logic signed [SUM_W-1:0]  div_sum;
    logic [SUM_W-1:0]         div_mag;
    logic                     div_done;
    logic [SUM_W-1:0]         div_quo;
    logic                     neg_reg;
    logic [SUM_W-1:0]         signed_quo;
    logic signed [COORD_W-1:0] mean_x_reg, mean_y_reg;
    logic [COORD_W-1:0]       mean_z_reg;

    // output register
    logic                     out_valid_reg;
    logic                     close_hit, far_hit;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            weight_reg <= WEIGHT_RESET;
            margin_reg <= MARGIN_RESET;
            near_reg   <= NEAR_RESET;
            far_reg    <= FAR_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SMOOTHING_WEIGHT: weight_reg <= cfg_data[WEIGHT_W-1:0];
                CFG_CHANGE_MARGIN:    margin_reg <= cfg_data[MARGIN_W-1:0];
                CFG_NEAR_WARNING:     near_reg   <= cfg_data[COORD_W-1:0];
                CFG_FAR_WARNING:      far_reg    <= cfg_data[COORD_W-1:0];
                default:              ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (point.valid) state_next = ST_WIN;
            ST_WIN:  state_next = ST_GRAB;
            ST_GRAB: state_next = ST_HYST;
            ST_HYST: state_next = ST_DIV;
            ST_DIV:  if (div_done && axis_reg == AX_Z) state_next = ST_OUT;
            ST_OUT:  if (!out_valid_reg || result.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer: control outputs
    always_comb
    begin
        ctl = '0;
        ctl.div_axis = AX_X;
        unique case (state_reg)
            ST_IDLE: ctl.in_ready = 1'b1;
            ST_WIN:  ctl.win_en   = 1'b1;
            ST_GRAB: ctl.grab_en  = 1'b1;
            ST_HYST:
            begin
                ctl.hyst_en   = 1'b1;
                ctl.div_start = 1'b1;
                ctl.div_axis  = AX_X;
            end
            ST_DIV:
            begin
                // chain the next axis as soon as one quotient is back
                ctl.div_start = div_done && (axis_reg != AX_Z);
                ctl.div_axis  = (axis_reg == AX_X) ? AX_Y : AX_Z;
            end
            ST_OUT:  ctl.out_load = !out_valid_reg || result.ready;
            default: ;
        endcase
    end

    always_comb
    begin
        axis_next = axis_reg;
        if (ctl.div_start)
        begin
            axis_next = ctl.div_axis;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            axis_reg  <= AX_X;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
        end
    end

    assign point.ready = ctl.in_ready;

    // capture the item at accept
    always_ff @(posedge clk)
    begin
        if (ctl.in_ready && point.valid)
        begin
            pt_reg.x <= point.hand_x;
            pt_reg.y <= point.hand_y;
            pt_reg.z <= point.hand_z;
            seen_reg <= point.grab_seen;
        end
    end

    // ---------------------------------------------------------------
    // window update: replace oldest entry once full
    // ---------------------------------------------------------------
    assign full = (held_reg == CNT_W'(WINDOW_POINTS));

    always_comb
    begin
        held_next  = held_reg;
        slot_next  = slot_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        sum_z_next = sum_z_reg;
        if (ctl.win_en)
        begin
            sum_x_next = sum_x_reg + SUM_W'(pt_reg.x);
            sum_y_next = sum_y_reg + SUM_W'(pt_reg.y);
            sum_z_next = sum_z_reg + $signed({{(SUM_W-COORD_W){1'b0}}, pt_reg.z});
            if (full)
            begin
                sum_x_next = sum_x_next - SUM_W'(old_pt_reg.x);
                sum_y_next = sum_y_next - SUM_W'(old_pt_reg.y);
                sum_z_next = sum_z_next - $signed({{(SUM_W-COORD_W){1'b0}}, old_pt_reg.z});
            end
            else
            begin
                held_next = held_reg + 1'b1;
            end
            slot_next = (slot_reg == SLOT_W'(WINDOW_POINTS - 1)) ? '0 : slot_reg + 1'b1;
        end
    end

    // oldest entry is read at accept, slot stays put until the window step
    always_ff @(posedge clk)
    begin
        if (ctl.in_ready && point.valid)
        begin
            old_pt_reg <= win_mem[slot_reg];
        end
        if (ctl.win_en)
        begin
            win_mem[slot_reg] <= pt_reg;
        end
    end

    // ---------------------------------------------------------------
    // grab average: r' = (w*r + (256-w)*256*seen) >> 8, weight capped at one
    // ---------------------------------------------------------------
    always_comb
    begin
        w_eff     = (weight_reg > GRAB_ONE) ? GRAB_ONE : weight_reg;
        grab_prod = w_eff * grab_reg;
        grab_sum  = grab_prod
                  + (seen_reg ? {1'b0, GRAB_ONE - w_eff, 8'd0} : '0);
        grab_next = ctl.grab_en ? grab_sum[WEIGHT_W+7:8] : grab_reg;
    end

    // hysteresis on the registered average; margin above half never sets or clears
    always_comb
    begin
        r_ext         = {1'b0, grab_reg};
        m_ext         = {2'b0, margin_reg};
        active_next   = active_reg;
        started_next  = started_reg;
        released_next = released_reg;
        if (ctl.hyst_en)
        begin
            started_next  = 1'b0;
            released_next = 1'b0;
            if (!active_reg)
            begin
                if (r_ext > GRAB_HALF + m_ext)
                begin
                    active_next  = 1'b1;
                    started_next = 1'b1;
                end
            end
            else if ((r_ext + m_ext) < GRAB_HALF)
            begin
                active_next   = 1'b0;
                released_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= '0;
            slot_reg     <= '0;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            sum_z_reg    <= '0;
            grab_reg     <= '0;
            active_reg   <= 1'b0;
            started_reg  <= 1'b0;
            released_reg <= 1'b0;
        end
        else
        begin
            held_reg     <= held_next;
            slot_reg     <= slot_next;
            sum_x_reg    <= sum_x_next;
            sum_y_reg    <= sum_y_next;
            sum_z_reg    <= sum_z_next;
            grab_reg     <= grab_next;
            active_reg   <= active_next;
            started_reg  <= started_next;
            released_reg <= released_next;
        end
    end

    // ---------------------------------------------------------------
    // mean: magnitude through the shared divider, sign put back after
    // ---------------------------------------------------------------
    always_comb
    begin
        case (ctl.div_axis)
            AX_X:    div_sum = sum_x_reg;
            AX_Y:    div_sum = sum_y_reg;
            default: div_sum = sum_z_reg;
        endcase
        div_mag = div_sum[SUM_W-1] ? SUM_W'(-div_sum) : SUM_W'(div_sum);
    end

    hpsgh_div #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ctl.div_start),
        .dividend (div_mag),
        .divisor  (held_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign signed_quo = neg_reg ? SUM_W'(-div_quo) : div_quo;

    always_ff @(posedge clk)
    begin
        if (ctl.div_start)
        begin
            neg_reg <= div_sum[SUM_W-1];
        end
        if (div_done)
        begin
            case (axis_reg)
                AX_X:    mean_x_reg <= $signed(signed_quo[COORD_W-1:0]);
                AX_Y:    mean_y_reg <= $signed(signed_quo[COORD_W-1:0]);
                default: mean_z_reg <= signed_quo[COORD_W-1:0];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------
    assign close_hit = (pt_reg.z < near_reg);
    assign far_hit   = !close_hit && (pt_reg.z > far_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctl.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.out_load)
        begin
            result.smooth_x      <= mean_x_reg;
            result.smooth_y      <= mean_y_reg;
            result.smooth_z      <= mean_z_reg;
            result.grabbing      <= active_reg;
            result.grab_started  <= started_reg;
            result.grab_released <= released_reg;
            result.too_close     <= close_hit;
            result.too_far       <= far_hit;
        end
    end

    assign result.valid = out_valid_reg;

    // ---------------------------------------------------------------
    // checks
    // ---------------------------------------------------------------
    property p_grab_in_range;
        @(posedge clk) disable iff (!rst_n) grab_reg <= GRAB_ONE;
    endproperty
    a_grab_in_range: assert property (p_grab_in_range)
        else $error("running grab value above one");

    property p_held_in_range;
        @(posedge clk) disable iff (!rst_n)
            (held_reg <= CNT_W'(WINDOW_POINTS)) && (slot_reg <= SLOT_W'(WINDOW_POINTS - 1));
    endproperty
    a_held_in_range: assert property (p_held_in_range)
        else $error("window count or slot out of range");

    property p_start_sets_grab;
        @(posedge clk) disable iff (!rst_n)
            (out_valid_reg && result.grab_started) |-> (result.grabbing && !result.grab_released);
    endproperty
    a_start_sets_grab: assert property (p_start_sets_grab)
        else $error("grab start pulse without grab state");

    property p_release_clears_grab;
        @(posedge clk) disable iff (!rst_n)
            (out_valid_reg && result.grab_released) |-> !result.grabbing;
    endproperty
    a_release_clears_grab: assert property (p_release_clears_grab)
        else $error("grab release pulse with grab state set");

    property p_div_only_with_points;
        @(posedge clk) disable iff (!rst_n) ctl.div_start |-> (held_reg != '0);
    endproperty
    a_div_only_with_points: assert property (p_div_only_with_points)
        else $error("mean taken over an empty window");

endmodule
